// ----- rtl/lzcp_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the crossing probability pipeline.
// Used by lzcp_front, lzcp_expo and landau_zener_crossing_prob.
package lzcp_pkg;

   localparam int MAX_CELLS = 65536;
   localparam logic [16:0] CELL_LIMIT = 17'(MAX_CELLS);

   localparam int CSR_INDEX_W = 3;
   localparam logic [CSR_INDEX_W-1:0] REG_SOC_ELEMENT = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_GRADIENT_DIFFERENCE = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_REDUCED_MASS = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_BARRIER_HEIGHT = 3'd3;

   localparam logic [29:0] LZ_K48 = 30'd1038575673;
   localparam logic [31:0] LZ_E1 = 32'd1580030169;
   localparam logic [3:0] Y_SAT_WHOLE = 4'd12;

   localparam int DIV1_STEPS = 64;
   localparam int SQRT_STEPS = 32;
   localparam int MULT_STAGES = 4;
   localparam int DIV2_STEPS = 28;
   localparam int HORNER_TERMS = 13;
   localparam int EXP_STEPS = 11;
   localparam int PIPE_DEPTH = 1 + DIV1_STEPS + SQRT_STEPS + MULT_STAGES + 1 + DIV2_STEPS
                               + 3 * HORNER_TERMS + EXP_STEPS + 1;

   typedef struct packed {
      logic zero;
      logic sat;
   } lzcp_flag_type;

   typedef struct packed {
      lzcp_flag_type flags;
      logic [3:0] whole;
      logic [31:0] frac;
   } lzcp_meta_type;

endpackage

// ----- rtl/lzcp_front.sv -----
`timescale 1ns / 1ps
// Front pipeline: energy, mass/energy divide, square root, scaling products, divide by gradient.
// Depends on lzcp_pkg.
module lzcp_front (
   input  logic                   clock,
   input  logic                   en,
   input  logic [15:0]            cell_index,
   input  logic [31:0]            gradient_difference,
   input  logic [31:0]            reduced_mass,
   input  logic [31:0]            barrier_height,
   input  logic [47:0]            soc_sq,
   input  logic [59:0]            sat_limit,
   output logic [27:0]            y_scaled,
   output lzcp_pkg::lzcp_flag_type flags
);
   import lzcp_pkg::*;

   logic [31:0] cell_q8;
   logic [31:0] energy_full;
   logic        below;
   logic        zero_e_ff;
   logic [23:0] e_ff;

   assign cell_q8 = {8'h00, cell_index, 8'h00};
   assign energy_full = cell_q8 - barrier_height;
   assign below = (cell_q8 <= barrier_height) || ({1'b0, cell_index} >= CELL_LIMIT)
                  || (gradient_difference == 32'h0);

   always_ff @(posedge clock) begin
      if (en) begin
         zero_e_ff <= below;
         e_ff <= energy_full[23:0];
      end
   end

   logic [23:0] d1_rem_ff  [1:DIV1_STEPS];
   logic [23:0] d1_den_ff  [1:DIV1_STEPS];
   logic [63:0] d1_quo_ff  [1:DIV1_STEPS];
   logic        d1_zero_ff [1:DIV1_STEPS];

   for (genvar k = 1; k <= DIV1_STEPS; k++) begin : g_div1
      logic [23:0] rem_p;
      logic [23:0] den_p;
      logic [63:0] quo_p;
      logic        zero_p;
      logic        num_bit;
      logic [24:0] shifted;
      logic        take;
      if (k == 1) begin : g_first
         assign rem_p = '0;
         assign den_p = e_ff;
         assign quo_p = '0;
         assign zero_p = zero_e_ff;
      end else begin : g_next
         assign rem_p = d1_rem_ff[k-1];
         assign den_p = d1_den_ff[k-1];
         assign quo_p = d1_quo_ff[k-1];
         assign zero_p = d1_zero_ff[k-1];
      end
      if (k <= 32) begin : g_num
         assign num_bit = reduced_mass[32-k];
      end else begin : g_pad
         assign num_bit = 1'b0;
      end
      assign shifted = {rem_p, num_bit};
      assign take = shifted >= {1'b0, den_p};
      always_ff @(posedge clock) begin
         if (en) begin
            d1_rem_ff[k] <= take ? 24'(shifted - {1'b0, den_p}) : shifted[23:0];
            d1_den_ff[k] <= den_p;
            d1_quo_ff[k] <= {quo_p[62:0], take};
            d1_zero_ff[k] <= zero_p;
         end
      end
   end

   logic [32:0] sq_rem_ff  [1:SQRT_STEPS];
   logic [31:0] sq_root_ff [1:SQRT_STEPS];
   logic [63:0] sq_rad_ff  [1:SQRT_STEPS];
   logic        sq_zero_ff [1:SQRT_STEPS];

   for (genvar k = 1; k <= SQRT_STEPS; k++) begin : g_sqrt
      logic [32:0] rem_p;
      logic [31:0] root_p;
      logic [63:0] rad_p;
      logic        zero_p;
      logic [34:0] rem2;
      logic [34:0] trial;
      logic        take;
      if (k == 1) begin : g_first
         assign rem_p = '0;
         assign root_p = '0;
         assign rad_p = d1_quo_ff[DIV1_STEPS];
         assign zero_p = d1_zero_ff[DIV1_STEPS];
      end else begin : g_next
         assign rem_p = sq_rem_ff[k-1];
         assign root_p = sq_root_ff[k-1];
         assign rad_p = sq_rad_ff[k-1];
         assign zero_p = sq_zero_ff[k-1];
      end
      assign rem2 = {rem_p, rad_p[63:62]};
      assign trial = {1'b0, root_p, 2'b01};
      assign take = rem2 >= trial;
      always_ff @(posedge clock) begin
         if (en) begin
            sq_rem_ff[k] <= take ? 33'(rem2 - trial) : rem2[32:0];
            sq_root_ff[k] <= {root_p[30:0], take};
            sq_rad_ff[k] <= {rad_p[61:0], 2'b00};
            sq_zero_ff[k] <= zero_p;
         end
      end
   end

   logic [63:0] plo_ff;
   logic [47:0] phi_ff;
   logic        m1_zero_ff;
   logic [59:0] a2_ff;
   logic        m2_zero_ff;
   logic [61:0] klo_ff;
   logic [57:0] khi_ff;
   logic        m3_zero_ff;
   logic [63:0] a3_ff;
   logic        m4_zero_ff;
   logic [79:0] a2_sum;
   logic [89:0] a3_sum;
   logic [73:0] a3_wide;

   assign a2_sum = {phi_ff, 32'h0} + {16'h0, plo_ff};
   assign a3_sum = {khi_ff, 32'h0} + {28'h0, klo_ff};
   assign a3_wide = a3_sum[89:16];

   always_ff @(posedge clock) begin
      if (en) begin
         plo_ff <= 64'(soc_sq[31:0]) * 64'(sq_root_ff[SQRT_STEPS]);
         phi_ff <= 48'(soc_sq[47:32]) * 48'(sq_root_ff[SQRT_STEPS]);
         m1_zero_ff <= sq_zero_ff[SQRT_STEPS];
         a2_ff <= a2_sum[79:20];
         m2_zero_ff <= m1_zero_ff;
         klo_ff <= 62'(a2_ff[31:0]) * 62'(LZ_K48);
         khi_ff <= 58'(a2_ff[59:32]) * 58'(LZ_K48);
         m3_zero_ff <= m2_zero_ff;
         a3_ff <= (|a3_wide[73:64]) ? '1 : a3_wide[63:0];
         m4_zero_ff <= m3_zero_ff;
      end
   end

   logic [31:0]   z_rem_ff;
   logic [27:0]   z_low_ff;
   lzcp_flag_type z_flags_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         z_rem_ff <= a3_ff[59:28];
         z_low_ff <= a3_ff[27:0];
         z_flags_ff.zero <= m4_zero_ff;
         z_flags_ff.sat <= a3_ff >= {4'h0, sat_limit};
      end
   end

   logic [31:0]   d2_rem_ff   [1:DIV2_STEPS];
   logic [27:0]   d2_low_ff   [1:DIV2_STEPS];
   logic [27:0]   d2_quo_ff   [1:DIV2_STEPS];
   lzcp_flag_type d2_flags_ff [1:DIV2_STEPS];

   for (genvar k = 1; k <= DIV2_STEPS; k++) begin : g_div2
      logic [31:0]   rem_p;
      logic [27:0]   low_p;
      logic [27:0]   quo_p;
      lzcp_flag_type flags_p;
      logic [32:0]   shifted;
      logic          take;
      if (k == 1) begin : g_first
         assign rem_p = z_rem_ff;
         assign low_p = z_low_ff;
         assign quo_p = '0;
         assign flags_p = z_flags_ff;
      end else begin : g_next
         assign rem_p = d2_rem_ff[k-1];
         assign low_p = d2_low_ff[k-1];
         assign quo_p = d2_quo_ff[k-1];
         assign flags_p = d2_flags_ff[k-1];
      end
      assign shifted = {rem_p, low_p[27]};
      assign take = shifted >= {1'b0, gradient_difference};
      always_ff @(posedge clock) begin
         if (en) begin
            d2_rem_ff[k] <= take ? 32'(shifted - {1'b0, gradient_difference}) : shifted[31:0];
            d2_low_ff[k] <= {low_p[26:0], 1'b0};
            d2_quo_ff[k] <= {quo_p[26:0], take};
            d2_flags_ff[k] <= flags_p;
         end
      end
   end

   assign y_scaled = d2_quo_ff[DIV2_STEPS];
   assign flags = d2_flags_ff[DIV2_STEPS];

endmodule

// ----- rtl/lzcp_expo.sv -----
`timescale 1ns / 1ps
// Exponential pipeline: Horner series for the fraction, e^-1 products, rounding to Q0.16.
// Depends on lzcp_pkg.
module lzcp_expo (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    en,
   input  logic [27:0]             y_scaled,
   input  lzcp_pkg::lzcp_flag_type flags,
   output logic [15:0]             prob
);
   import lzcp_pkg::*;

   localparam logic [32:0] ONE = 33'h1_0000_0000;
   localparam logic [35:0] RECIP [1:HORNER_TERMS] = '{
      36'd34359738368, 36'd17179869184, 36'd11453246122, 36'd8589934592,
      36'd6871947673,  36'd5726623061,  36'd4908534052,  36'd4294967296,
      36'd3817748707,  36'd3435973836,  36'd3123612578,  36'd2863311530,
      36'd2643056797};

   lzcp_meta_type meta0;
   assign meta0.flags = flags;
   assign meta0.whole = y_scaled[27:24];
   assign meta0.frac = {y_scaled[23:0], 8'h00};

   lzcp_meta_type ha_meta_ff [0:HORNER_TERMS-1];
   logic [31:0]   ha_prod_ff [0:HORNER_TERMS-1];
   lzcp_meta_type hb_meta_ff [0:HORNER_TERMS-1];
   logic [31:0]   hb_prod_ff [0:HORNER_TERMS-1];
   logic [31:0]   hb_est_ff  [0:HORNER_TERMS-1];
   lzcp_meta_type hc_meta_ff [0:HORNER_TERMS-1];
   logic [32:0]   hc_t_ff    [0:HORNER_TERMS-1];

   for (genvar j = 0; j < HORNER_TERMS; j++) begin : g_term
      localparam logic [3:0] DIVISOR = 4'(HORNER_TERMS - j);
      lzcp_meta_type meta_p;
      logic [32:0]   t_p;
      logic [64:0]   ft;
      logic [67:0]   scaled;
      logic [35:0]   back;
      logic [35:0]   rm;
      logic          fix;
      logic [31:0]   quo;
      if (j == 0) begin : g_first
         assign meta_p = meta0;
         assign t_p = ONE;
      end else begin : g_next
         assign meta_p = hc_meta_ff[j-1];
         assign t_p = hc_t_ff[j-1];
      end
      assign ft = 65'(meta_p.frac) * 65'(t_p);
      assign scaled = 68'(ha_prod_ff[j]) * 68'(RECIP[DIVISOR]);
      assign back = 36'(hb_est_ff[j]) * 36'(DIVISOR);
      assign rm = 36'(hb_prod_ff[j]) - back;
      assign fix = rm >= 36'(DIVISOR);
      assign quo = hb_est_ff[j] + 32'(fix);
      always_ff @(posedge clock) begin
         if (en) begin
            ha_meta_ff[j] <= meta_p;
            ha_prod_ff[j] <= ft[63:32];
            hb_meta_ff[j] <= ha_meta_ff[j];
            hb_prod_ff[j] <= ha_prod_ff[j];
            hb_est_ff[j] <= scaled[66:35];
            hc_meta_ff[j] <= hb_meta_ff[j];
            hc_t_ff[j] <= ONE - 33'(quo);
         end
      end
   end

   lzcp_meta_type ex_meta_ff [0:EXP_STEPS-1];
   logic [32:0]   ex_val_ff  [0:EXP_STEPS-1];

   for (genvar k = 0; k < EXP_STEPS; k++) begin : g_exp
      lzcp_meta_type meta_p;
      logic [32:0]   val_p;
      logic [65:0]   mul;
      if (k == 0) begin : g_first
         assign meta_p = hc_meta_ff[HORNER_TERMS-1];
         assign val_p = hc_t_ff[HORNER_TERMS-1];
      end else begin : g_next
         assign meta_p = ex_meta_ff[k-1];
         assign val_p = ex_val_ff[k-1];
      end
      assign mul = 66'(val_p) * 66'(LZ_E1) + 66'h0_8000_0000;
      always_ff @(posedge clock) begin
         if (en) begin
            ex_meta_ff[k] <= meta_p;
            ex_val_ff[k] <= (4'(k) < meta_p.whole) ? mul[64:32] : val_p;
         end
      end
   end

   lzcp_meta_type last_meta;
   logic [33:0]   diff;
   logic [17:0]   rounded;
   logic [15:0]   prob_in;
   logic [15:0]   prob_ff;

   assign last_meta = ex_meta_ff[EXP_STEPS-1];
   assign diff = 34'(ONE) - 34'(ex_val_ff[EXP_STEPS-1]) + 34'h8000;
   assign rounded = diff[33:16];

   always_comb begin
      if (last_meta.flags.zero) begin
         prob_in = '0;
      end else if (last_meta.flags.sat || (rounded > 18'h0FFFF)) begin
         prob_in = '1;
      end else begin
         prob_in = rounded[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prob_ff <= prob_in;
      end
   end

   assign prob = prob_ff;

   a_zero_result: assert property (@(posedge clock) disable iff (reset)
      en && last_meta.flags.zero |=> prob_ff == 16'h0000)
      else $error("zero flag did not give a zero result");
   a_sat_result: assert property (@(posedge clock) disable iff (reset)
      en && last_meta.flags.sat && !last_meta.flags.zero |=> prob_ff == 16'hFFFF)
      else $error("saturated exponent did not give full scale");
   a_hold_result: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(prob_ff))
      else $error("result register moved while stalled");

endmodule

// ----- rtl/landau_zener_crossing_prob.sv -----
`timescale 1ns / 1ps
// Top level: configuration registers, valid pipeline, output skid entry.
// Depends on lzcp_pkg, lzcp_front and lzcp_expo.
//
// Landau-Zener crossing probability, one energy cell per beat.
// Fully pipelined: a new cell is taken every cycle while the skid entry is
// empty; most of the pipeline depth comes from the bit-serial stages of the
// two restoring divides (64 and 28 steps), the 32-step square root and the
// 13-term Horner series; each divide or root step is one register stage and
// each Horner term three. When the result side stalls, one result drops into
// a skid entry and the pipeline holds until it is taken. Write the registers
// only with no beat in flight; the coupling square and the saturation limit
// are registered from the written values.
module landau_zener_crossing_prob (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [15:0] req_cell_index,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_crossing_probability,
   input  logic        csr_wr_en,
   input  logic [lzcp_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [31:0] csr_wr_data
);
   import lzcp_pkg::*;

   logic [31:0] soc_ff;
   logic [31:0] grad_ff;
   logic [31:0] mass_ff;
   logic [31:0] barrier_ff;
   logic [47:0] soc_sq_ff;
   logic [59:0] sat_limit_ff;
   logic [63:0] soc_full;
   logic [35:0] grad_x12;

   always_ff @(posedge clock) begin
      if (reset) begin
         soc_ff <= '0;
         grad_ff <= '0;
         mass_ff <= '0;
         barrier_ff <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            REG_SOC_ELEMENT: soc_ff <= csr_wr_data;
            REG_GRADIENT_DIFFERENCE: grad_ff <= csr_wr_data;
            REG_REDUCED_MASS: mass_ff <= csr_wr_data;
            REG_BARRIER_HEIGHT: barrier_ff <= csr_wr_data;
            default: ;
         endcase
      end
   end

   assign soc_full = 64'(soc_ff) * 64'(soc_ff);
   assign grad_x12 = 36'(grad_ff) * 36'(Y_SAT_WHOLE);

   always_ff @(posedge clock) begin
      soc_sq_ff <= soc_full[63:16];
      sat_limit_ff <= {grad_x12, 24'h000000};
   end

   logic                   en;
   logic [PIPE_DEPTH-1:0]  vld_ff;
   logic                   vld_last;
   logic [27:0]            y_scaled;
   lzcp_flag_type          flags;
   logic [15:0]            prob;
   logic                   skid_vld_ff;
   logic                   skid_vld_in;
   logic [15:0]            skid_prob_ff;

   assign en = !skid_vld_ff;
   assign req_ready = en;
   assign vld_last = vld_ff[PIPE_DEPTH-1];

   lzcp_front u_front (
      .clock               (clock),
      .en                  (en),
      .cell_index          (req_cell_index),
      .gradient_difference (grad_ff),
      .reduced_mass        (mass_ff),
      .barrier_height      (barrier_ff),
      .soc_sq              (soc_sq_ff),
      .sat_limit           (sat_limit_ff),
      .y_scaled            (y_scaled),
      .flags               (flags)
   );

   lzcp_expo u_expo (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .y_scaled (y_scaled),
      .flags    (flags),
      .prob     (prob)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[PIPE_DEPTH-2:0], req_valid};
      end
   end

   assign skid_vld_in = skid_vld_ff ? !rsp_ready : (vld_last && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         skid_vld_ff <= 1'b0;
      end else begin
         skid_vld_ff <= skid_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!skid_vld_ff && vld_last && !rsp_ready) begin
         skid_prob_ff <= prob;
      end
   end

   assign rsp_valid = skid_vld_ff || vld_last;
   assign rsp_crossing_probability = skid_vld_ff ? skid_prob_ff : prob;

   a_skid_capture: assert property (@(posedge clock) disable iff (reset)
      vld_last && !skid_vld_ff && !rsp_ready |=> skid_vld_ff && skid_prob_ff == $past(prob))
      else $error("stalled beat not captured in skid entry");
   a_freeze: assert property (@(posedge clock) disable iff (reset)
      skid_vld_ff |=> $stable(vld_ff))
      else $error("pipeline moved while skid entry occupied");
   a_skid_drain: assert property (@(posedge clock) disable iff (reset)
      skid_vld_ff && rsp_ready |=> !skid_vld_ff)
      else $error("skid entry not released after beat taken");

endmodule
